// ===== rtl/pagerank_csr_active_vertex_macros.svh =====
// Assertion macros used by the checker file.
`ifndef PAGERANK_CSR_ACTIVE_VERTEX_MACROS_SVH
`define PAGERANK_CSR_ACTIVE_VERTEX_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define PCAV_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define PCAV_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pcav_pkg.sv =====
package pcav_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int MAX_EDGES    = 8192;
   localparam int VTX_W        = 10;
   localparam int VCNT_W       = 11;
   localparam int EDGE_W       = 13;
   localparam int EOFF_W       = 14;
   localparam int RANK_W       = 32;
   localparam int FRAC_BITS    = 30;
   localparam int CHG_W        = 40;
   localparam int CFG_Q_W      = 31;
   localparam int ITER_W       = 10;
   localparam int CSR_IDX_W    = 2;

   localparam logic [RANK_W-1:0] ONE_Q = RANK_W'(64'd1 << FRAC_BITS);

   // request commands
   localparam logic [1:0] CMD_LOAD_OFFSET   = 2'd0;
   localparam logic [1:0] CMD_LOAD_NEIGHBOR = 2'd1;
   localparam logic [1:0] CMD_RUN           = 2'd2;
   localparam logic [1:0] CMD_READ_RANK     = 2'd3;

   // response kinds
   localparam logic [1:0] KIND_RUN_DONE  = 2'd0;
   localparam logic [1:0] KIND_RANK      = 2'd1;
   localparam logic [1:0] KIND_INDEX_ERR = 2'd2;

   // csr indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON      = 2'd3;

endpackage

// ===== rtl/pagerank_csr_active_vertex.sv =====
// PageRank engine over a CSR graph with per-vertex activity tracking.
// req_*: one command per transfer (load offset, load neighbor, run, read rank).
//   req_stall is high while a command is in work or a response is pending.
// rsp_*: one response transfer for run, read and out-of-range errors;
//   successful loads return nothing. The response register holds under
//   rsp_stall, and no new command is taken until it has been transferred.
// csr_*: register writes, always ready; write only while the block is idle.
// Loads are written at the end of the transfer cycle. A rank read passes the
// READ state and answers with a registered response. A run first sweeps all
// 1024 vertices (rank, sum and marks), then per iteration updates each vertex
// (UPD_RD, UPD_MUL, UPD_NV, UPD_ACC), spreads from each (SP_RD, SP_OFF, SP_HI),
// divides once per active vertex with edges (one shared restoring divider, one
// quotient bit a cycle) and per in-graph edge does a sum read-modify-write.
// Reset (synchronous, active high) returns the CSRs to defaults and the
// sequencer to idle; graph and rank memories are not cleared.
// Activity uses iteration marks in the vertex memory, so no clearing pass
// is needed between iterations.
module pagerank_csr_active_vertex (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [13:0] req_index,
   input  logic [13:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [9:0]  rsp_vertex,
   output logic [31:0] rsp_rank,
   output logic [9:0]  rsp_iterations_run,
   output logic        rsp_converged,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_wdata
);

   // sequencer states
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_READ    = 4'd1;
   localparam logic [3:0] ST_INIT    = 4'd2;
   localparam logic [3:0] ST_UPD_RD  = 4'd3;
   localparam logic [3:0] ST_UPD_MUL = 4'd4;
   localparam logic [3:0] ST_UPD_NV  = 4'd5;
   localparam logic [3:0] ST_UPD_ACC = 4'd6;
   localparam logic [3:0] ST_CHECK   = 4'd7;
   localparam logic [3:0] ST_SP_RD   = 4'd8;
   localparam logic [3:0] ST_SP_OFF  = 4'd9;
   localparam logic [3:0] ST_SP_HI   = 4'd10;
   localparam logic [3:0] ST_SP_DIV  = 4'd11;
   localparam logic [3:0] ST_E_RD    = 4'd12;
   localparam logic [3:0] ST_E_CHK   = 4'd13;
   localparam logic [3:0] ST_E_ADD   = 4'd14;

   localparam int DIV_W  = pcav_pkg::RANK_W;
   localparam int REM_W  = pcav_pkg::EOFF_W + 1;
   localparam int DCNT_W = 6;

   // vertex memory row: spread-time activity carry, activity mark, rank sum
   typedef struct packed {
      logic                             prev;
      logic [pcav_pkg::ITER_W-1:0]      mark;
      logic [pcav_pkg::RANK_W-1:0]      sum;
   } vrow_type;

   // memories
   logic [pcav_pkg::EOFF_W-1:0] off_mem  [pcav_pkg::MAX_VERTICES+1];
   logic [pcav_pkg::EOFF_W-1:0] nbr_mem  [pcav_pkg::MAX_EDGES];
   logic [pcav_pkg::RANK_W-1:0] rank_mem [pcav_pkg::MAX_VERTICES];
   vrow_type                    vrow_mem [pcav_pkg::MAX_VERTICES];

   logic                          off_we, nbr_we, rank_we, vrow_we;
   logic [pcav_pkg::VCNT_W-1:0]   off_wa, off_ra;
   logic [pcav_pkg::EDGE_W-1:0]   nbr_wa, nbr_ra;
   logic [pcav_pkg::VTX_W-1:0]    rank_wa, rank_ra, vrow_wa, vrow_ra;
   logic [pcav_pkg::RANK_W-1:0]   rank_wd;
   vrow_type                      vrow_wd;
   logic [pcav_pkg::EOFF_W-1:0]   off_q, nbr_q;
   logic [pcav_pkg::RANK_W-1:0]   rank_q;
   vrow_type                      vrow_q;

   // registers
   logic [3:0]                    state_ff, state_in;
   logic [pcav_pkg::VCNT_W-1:0]   vcount_ff, vcount_in;
   logic [pcav_pkg::ITER_W-1:0]   max_iter_ff, max_iter_in;
   logic [pcav_pkg::CFG_Q_W-1:0]  damping_ff, damping_in;
   logic [pcav_pkg::CFG_Q_W-1:0]  epsilon_ff, epsilon_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    rsp_kind_ff, rsp_kind_in;
   logic [pcav_pkg::VTX_W-1:0]    rsp_vertex_ff, rsp_vertex_in;
   logic [pcav_pkg::RANK_W-1:0]   rsp_rank_ff, rsp_rank_in;
   logic [pcav_pkg::ITER_W-1:0]   rsp_iters_ff, rsp_iters_in;
   logic                          rsp_conv_ff, rsp_conv_in;
   logic [pcav_pkg::VCNT_W-1:0]   v_ff, v_in;
   logic [pcav_pkg::EOFF_W-1:0]   e_ff, e_in;
   logic [pcav_pkg::EOFF_W-1:0]   lo_ff, lo_in;
   logic [pcav_pkg::EOFF_W-1:0]   hi_ff, hi_in;
   logic [pcav_pkg::ITER_W-1:0]   iter_ff, iter_in;
   logic [pcav_pkg::CHG_W-1:0]    change_ff, change_in;
   logic [pcav_pkg::RANK_W-1:0]   base_ff, base_in;
   logic [62:0]                   prod_ff, prod_in;
   logic [pcav_pkg::RANK_W-1:0]   rank_ff, rank_in;
   logic [pcav_pkg::RANK_W-1:0]   nv_ff, nv_in;
   logic                          act_ff, act_in;
   logic                          prev_ff, prev_in;
   logic [pcav_pkg::ITER_W-1:0]   mark_ff, mark_in;
   logic [pcav_pkg::VTX_W-1:0]    nb_ff, nb_in;
   logic [pcav_pkg::VTX_W-1:0]    rd_vtx_ff, rd_vtx_in;
   logic [DIV_W-1:0]              div_num_ff, div_num_in;
   logic [REM_W-1:0]              div_rem_ff, div_rem_in;
   logic [pcav_pkg::EOFF_W-1:0]   div_den_ff, div_den_in;
   logic [DCNT_W-1:0]             div_cnt_ff, div_cnt_in;

   // combinational helpers
   logic [pcav_pkg::VCNT_W-1:0]   n_eff, v_p1;
   logic [pcav_pkg::EOFF_W-1:0]   e_p1, off_bound;
   logic [pcav_pkg::ITER_W-1:0]   iter_p1;
   logic [REM_W-1:0]              rem_sh;
   logic                          div_ge;
   logic [32:0]                   mq, nv_sum, esum;
   logic [pcav_pkg::RANK_W-1:0]   mq_sat, diff;
   logic [pcav_pkg::CHG_W:0]      chg_sum;
   logic                          req_take, edge_next, vtx_next;

   // effective vertex count: 0 acts as 1, clamp at capacity
   always_comb begin
      if (vcount_ff == '0) begin
         n_eff = pcav_pkg::VCNT_W'(1);
      end else if (vcount_ff > pcav_pkg::VCNT_W'(pcav_pkg::MAX_VERTICES)) begin
         n_eff = pcav_pkg::VCNT_W'(pcav_pkg::MAX_VERTICES);
      end else begin
         n_eff = vcount_ff;
      end
   end

   // offsets beyond the edge store clamp to its size
   assign off_bound = (off_q > pcav_pkg::EOFF_W'(pcav_pkg::MAX_EDGES)) ?
                      pcav_pkg::EOFF_W'(pcav_pkg::MAX_EDGES) : off_q;

   assign v_p1    = v_ff + 1'b1;
   assign e_p1    = e_ff + 1'b1;
   assign iter_p1 = iter_ff + 1'b1;

   // restoring divider step, one quotient bit per cycle
   assign rem_sh = {div_rem_ff[REM_W-2:0], div_num_ff[DIV_W-1]};
   assign div_ge = rem_sh >= {1'b0, div_den_ff};

   // update datapath: saturated (sum*damping)>>30, then + base
   assign mq     = prod_ff[62:pcav_pkg::FRAC_BITS];
   assign mq_sat = mq[32] ? '1 : mq[31:0];
   assign nv_sum = {1'b0, mq_sat} + {1'b0, base_ff};
   assign diff   = (nv_ff > rank_ff) ? (nv_ff - rank_ff) : (rank_ff - nv_ff);
   assign chg_sum = {1'b0, change_ff} + (pcav_pkg::CHG_W + 1)'(diff);

   // spread datapath: neighbor sum + share, saturated
   assign esum = {1'b0, vrow_q.sum} + {1'b0, div_num_ff};

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign csr_ready = 1'b1;

   // memory addresses
   assign rank_ra = (state_ff == ST_IDLE) ? req_index[pcav_pkg::VTX_W-1:0]
                                          : v_ff[pcav_pkg::VTX_W-1:0];
   assign vrow_ra = (state_ff == ST_E_CHK) ? nbr_q[pcav_pkg::VTX_W-1:0]
                                           : v_ff[pcav_pkg::VTX_W-1:0];
   assign off_ra  = (state_ff == ST_SP_OFF) ? v_p1 : v_ff;
   assign nbr_ra  = e_ff[pcav_pkg::EDGE_W-1:0];
   assign off_wa  = req_index[pcav_pkg::VCNT_W-1:0];
   assign nbr_wa  = req_index[pcav_pkg::EDGE_W-1:0];

   always_comb begin
      state_in     = state_ff;
      vcount_in    = vcount_ff;
      max_iter_in  = max_iter_ff;
      damping_in   = damping_ff;
      epsilon_in   = epsilon_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_rank_in  = rsp_rank_ff;
      rsp_iters_in = rsp_iters_ff;
      rsp_conv_in  = rsp_conv_ff;
      v_in         = v_ff;
      e_in         = e_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      iter_in      = iter_ff;
      change_in    = change_ff;
      base_in      = base_ff;
      prod_in      = prod_ff;
      rank_in      = rank_ff;
      nv_in        = nv_ff;
      act_in       = act_ff;
      prev_in      = prev_ff;
      mark_in      = mark_ff;
      nb_in        = nb_ff;
      rd_vtx_in    = rd_vtx_ff;
      div_num_in   = div_num_ff;
      div_rem_in   = div_rem_ff;
      div_den_in   = div_den_ff;
      div_cnt_in   = div_cnt_ff;
      off_we       = 1'b0;
      nbr_we       = 1'b0;
      rank_we      = 1'b0;
      vrow_we      = 1'b0;
      rank_wa      = v_ff[pcav_pkg::VTX_W-1:0];
      rank_wd      = pcav_pkg::ONE_Q;
      vrow_wa      = v_ff[pcav_pkg::VTX_W-1:0];
      vrow_wd      = '0;
      edge_next    = 1'b0;
      vtx_next     = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            pcav_pkg::CSR_VERTEX_COUNT: vcount_in   = csr_wdata[pcav_pkg::VCNT_W-1:0];
            pcav_pkg::CSR_MAX_ITER:     max_iter_in = csr_wdata[pcav_pkg::ITER_W-1:0];
            pcav_pkg::CSR_DAMPING:      damping_in  = csr_wdata;
            pcav_pkg::CSR_EPSILON:      epsilon_in  = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (div_cnt_ff != '0) begin
         div_rem_in = div_ge ? (rem_sh - {1'b0, div_den_ff}) : rem_sh;
         div_num_in = {div_num_ff[DIV_W-2:0], div_ge};
         div_cnt_in = div_cnt_ff - 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               // default response: index error with zero payload
               rsp_kind_in   = pcav_pkg::KIND_INDEX_ERR;
               rsp_vertex_in = '0;
               rsp_rank_in   = '0;
               rsp_iters_in  = '0;
               rsp_conv_in   = 1'b0;
               case (req_command)
                  pcav_pkg::CMD_LOAD_OFFSET: begin
                     if (req_index <= 14'(pcav_pkg::MAX_VERTICES)) begin
                        off_we = 1'b1;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  pcav_pkg::CMD_LOAD_NEIGHBOR: begin
                     if (req_index < 14'(pcav_pkg::MAX_EDGES)) begin
                        nbr_we = 1'b1;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  pcav_pkg::CMD_READ_RANK: begin
                     if (req_index < 14'(n_eff)) begin
                        rd_vtx_in = req_index[pcav_pkg::VTX_W-1:0];
                        state_in  = ST_READ;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  pcav_pkg::CMD_RUN: begin
                     state_in  = ST_INIT;
                     v_in      = '0;
                     change_in = '0;
                     // base term (1 - damping) / N on the shared divider
                     div_num_in = (damping_ff >= pcav_pkg::CFG_Q_W'(pcav_pkg::ONE_Q)) ? '0 :
                                  DIV_W'(pcav_pkg::CFG_Q_W'(pcav_pkg::ONE_Q) - damping_ff);
                     div_den_in = pcav_pkg::EOFF_W'(n_eff);
                     div_rem_in = '0;
                     div_cnt_in = DCNT_W'(DIV_W);
                  end
                  default: ;
               endcase
            end
         end

         ST_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = pcav_pkg::KIND_RANK;
            rsp_vertex_in = rd_vtx_ff;
            rsp_rank_in   = rank_q;
            state_in      = ST_IDLE;
         end

         ST_INIT: begin
            rank_we = 1'b1;
            vrow_we = 1'b1;
            v_in    = v_p1;
            if (v_ff == pcav_pkg::VCNT_W'(pcav_pkg::MAX_VERTICES - 1)) begin
               base_in = div_num_ff;
               v_in    = '0;
               iter_in = '0;
               if (max_iter_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = pcav_pkg::KIND_RUN_DONE;
                  rsp_vertex_in = '0;
                  rsp_rank_in   = '0;
                  rsp_iters_in  = '0;
                  rsp_conv_in   = 1'b0;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_UPD_RD;
               end
            end
         end

         ST_UPD_RD: begin
            state_in = ST_UPD_MUL;
         end

         ST_UPD_MUL: begin
            prod_in  = {31'b0, vrow_q.sum} * {32'b0, damping_ff};
            rank_in  = rank_q;
            mark_in  = vrow_q.mark;
            prev_in  = vrow_q.prev;
            act_in   = vrow_q.mark == iter_ff;
            state_in = ST_UPD_NV;
         end

         ST_UPD_NV: begin
            nv_in    = nv_sum[32] ? '1 : nv_sum[31:0];
            state_in = ST_UPD_ACC;
         end

         ST_UPD_ACC: begin
            // sum is consumed here, so clear it for the coming spread
            vrow_we = 1'b1;
            vrow_wd = '{prev: prev_ff, mark: mark_ff, sum: '0};
            if (act_ff) begin
               rank_we   = 1'b1;
               rank_wd   = nv_ff;
               change_in = chg_sum[pcav_pkg::CHG_W] ? '1 : chg_sum[pcav_pkg::CHG_W-1:0];
            end
            if (v_p1 == n_eff) begin
               state_in = ST_CHECK;
            end else begin
               v_in     = v_p1;
               state_in = ST_UPD_RD;
            end
         end

         ST_CHECK: begin
            if (change_ff < pcav_pkg::CHG_W'(epsilon_ff)) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = pcav_pkg::KIND_RUN_DONE;
               rsp_vertex_in = '0;
               rsp_rank_in   = '0;
               rsp_iters_in  = iter_ff;
               rsp_conv_in   = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               change_in = '0;
               v_in      = '0;
               state_in  = ST_SP_RD;
            end
         end

         ST_SP_RD: begin
            state_in = ST_SP_OFF;
         end

         ST_SP_OFF: begin
            // active now, even if an earlier vertex already marked it for next
            act_in   = (vrow_q.mark == iter_ff) ||
                       ((vrow_q.mark == iter_p1) && vrow_q.prev);
            rank_in  = rank_q;
            lo_in    = off_bound;
            state_in = ST_SP_HI;
         end

         ST_SP_HI: begin
            if (act_ff && (off_bound > lo_ff)) begin
               hi_in      = off_bound;
               e_in       = lo_ff;
               div_num_in = rank_ff;
               div_den_in = off_bound - lo_ff;
               div_rem_in = '0;
               div_cnt_in = DCNT_W'(DIV_W);
               state_in   = ST_SP_DIV;
            end else begin
               vtx_next = 1'b1;
            end
         end

         ST_SP_DIV: begin
            if (div_cnt_ff == '0) begin
               state_in = ST_E_RD;
            end
         end

         ST_E_RD: begin
            state_in = ST_E_CHK;
         end

         ST_E_CHK: begin
            // neighbors outside the graph count toward degree only
            if (nbr_q < pcav_pkg::EOFF_W'(n_eff)) begin
               nb_in    = nbr_q[pcav_pkg::VTX_W-1:0];
               state_in = ST_E_ADD;
            end else begin
               edge_next = 1'b1;
            end
         end

         ST_E_ADD: begin
            vrow_we = 1'b1;
            vrow_wa = nb_ff;
            vrow_wd.mark = iter_p1;
            vrow_wd.sum  = esum[32] ? '1 : esum[31:0];
            if (vrow_q.mark == iter_ff) begin
               vrow_wd.prev = 1'b1;
            end else if (vrow_q.mark == iter_p1) begin
               vrow_wd.prev = vrow_q.prev;
            end else begin
               vrow_wd.prev = 1'b0;
            end
            edge_next = 1'b1;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (edge_next) begin
         if (e_p1 == hi_ff) begin
            vtx_next = 1'b1;
         end else begin
            e_in     = e_p1;
            state_in = ST_E_RD;
         end
      end

      if (vtx_next) begin
         if (v_p1 == n_eff) begin
            // iteration done
            iter_in = iter_p1;
            v_in    = '0;
            if (iter_p1 == max_iter_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = pcav_pkg::KIND_RUN_DONE;
               rsp_vertex_in = '0;
               rsp_rank_in   = '0;
               rsp_iters_in  = iter_p1;
               rsp_conv_in   = 1'b0;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_UPD_RD;
            end
         end else begin
            v_in     = v_p1;
            state_in = ST_SP_RD;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcount_ff    <= pcav_pkg::VCNT_W'(1);
         max_iter_ff  <= pcav_pkg::ITER_W'(100);
         damping_ff   <= pcav_pkg::CFG_Q_W'(912680550);
         epsilon_ff   <= pcav_pkg::CFG_Q_W'(11);
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         max_iter_ff  <= max_iter_in;
         damping_ff   <= damping_in;
         epsilon_ff   <= epsilon_in;
         rsp_valid_ff <= rsp_valid_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rsp_kind_ff   <= rsp_kind_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_iters_ff  <= rsp_iters_in;
      rsp_conv_ff   <= rsp_conv_in;
      v_ff          <= v_in;
      e_ff          <= e_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      iter_ff       <= iter_in;
      change_ff     <= change_in;
      base_ff       <= base_in;
      prod_ff       <= prod_in;
      rank_ff       <= rank_in;
      nv_ff         <= nv_in;
      act_ff        <= act_in;
      prev_ff       <= prev_in;
      mark_ff       <= mark_in;
      nb_ff         <= nb_in;
      rd_vtx_ff     <= rd_vtx_in;
      div_num_ff    <= div_num_in;
      div_rem_ff    <= div_rem_in;
      div_den_ff    <= div_den_in;
   end

   // memories, registered read
   always_ff @(posedge clock) begin
      if (off_we) begin
         off_mem[off_wa] <= req_value;
      end
      off_q <= off_mem[off_ra];
   end

   always_ff @(posedge clock) begin
      if (nbr_we) begin
         nbr_mem[nbr_wa] <= req_value;
      end
      nbr_q <= nbr_mem[nbr_ra];
   end

   always_ff @(posedge clock) begin
      if (rank_we) begin
         rank_mem[rank_wa] <= rank_wd;
      end
      rank_q <= rank_mem[rank_ra];
   end

   always_ff @(posedge clock) begin
      if (vrow_we) begin
         vrow_mem[vrow_wa] <= vrow_wd;
      end
      vrow_q <= vrow_mem[vrow_ra];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_kind_ff;
   assign rsp_vertex         = rsp_vertex_ff;
   assign rsp_rank           = rsp_rank_ff;
   assign rsp_iterations_run = rsp_iters_ff;
   assign rsp_converged      = rsp_conv_ff;

endmodule

// ===== rtl/pcav_checker.sv =====
`include "pagerank_csr_active_vertex_macros.svh"

module pcav_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_result_kind,
   input logic [9:0]  rsp_vertex,
   input logic [31:0] rsp_rank,
   input logic [9:0]  rsp_iterations_run,
   input logic        rsp_converged
);

   // stalled response holds
   `PCAV_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_rank) && $stable(rsp_result_kind) && $stable(rsp_iterations_run), "response changed under stall")

   // run-done carries no vertex or rank
   `PCAV_ASSERT_IMP(a_run_payload, rsp_valid && (rsp_result_kind == pcav_pkg::KIND_RUN_DONE), (rsp_vertex == '0) && (rsp_rank == '0), "run response has read payload")

   // rank read carries no run status
   `PCAV_ASSERT_IMP(a_read_payload, rsp_valid && (rsp_result_kind == pcav_pkg::KIND_RANK), (rsp_iterations_run == '0) && !rsp_converged, "read response has run status")

   // errors carry an all-zero payload
   `PCAV_ASSERT_IMP(a_err_payload, rsp_valid && (rsp_result_kind == pcav_pkg::KIND_INDEX_ERR), (rsp_vertex == '0) && (rsp_rank == '0) && (rsp_iterations_run == '0) && !rsp_converged, "error response has payload")

endmodule

bind pagerank_csr_active_vertex pcav_checker u_pcav_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_result_kind    (rsp_result_kind),
   .rsp_vertex         (rsp_vertex),
   .rsp_rank           (rsp_rank),
   .rsp_iterations_run (rsp_iterations_run),
   .rsp_converged      (rsp_converged)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

// PageRank engine bench: graph loads, runs, rank reads and bad indexes are fed
// through a bursty driver; every response is checked against an in-bench
// fixed-point PageRank calculation done when the command transfer happens.
module tb_top;
   import pcav_pkg::*;

   typedef struct packed {
      logic [1:0]  command;
      logic [13:0] index;
      logic [13:0] value;
   } pr_cmd_t;

   typedef struct packed {
      logic [1:0]  kind;
      logic [9:0]  vertex;
      logic [31:0] rank;
      logic [9:0]  iters;
      logic        conv;
   } pr_rsp_t;

   localparam longint unsigned RANK_TOP  = 64'hFFFF_FFFF;
   localparam longint unsigned CHG_TOP   = (64'd1 << 40) - 1;
   localparam longint unsigned Q_ONE     = 64'd1 << FRAC_BITS;
   localparam int              IDLE_LIMIT = 1_000_000;
   localparam int              ITEM_GOAL  = 1850;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = '0;
   logic [13:0] req_index = '0;
   logic [13:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [9:0]  rsp_vertex;
   logic [31:0] rsp_rank;
   logic [9:0]  rsp_iterations_run;
   logic        rsp_converged;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [30:0] csr_wdata = '0;

   pagerank_csr_active_vertex dut (.*);

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Graph / rank shadow state and CSR copies (CSR reset defaults)
   // ------------------------------------------------------------------
   logic [13:0]     g_offset [0:MAX_VERTICES];
   logic [13:0]     g_nbr    [0:MAX_EDGES-1];
   longint unsigned g_rank   [0:MAX_VERTICES-1];
   longint unsigned g_sum    [0:MAX_VERTICES-1];
   bit              g_active [0:MAX_VERTICES-1];
   bit              g_next   [0:MAX_VERTICES-1];

   logic [10:0] c_vcount = 11'd1;
   logic [9:0]  c_maxit  = 10'd100;
   logic [30:0] c_damp   = 31'd912680550;
   logic [30:0] c_eps    = 31'd11;

   pr_cmd_t pending_cmds [$];
   pr_rsp_t expected_rsp [$];
   int      fail_count = 0;
   int      cmds_queued = 0;

   function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b,
                                               longint unsigned top);
      if (a >= top || b >= top - a) return top;
      return a + b;
   endfunction

   // Q2.30 product, truncating, saturated to the rank width
   function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
      longint unsigned hi, lo;
      hi = (a >> FRAC_BITS) * b;
      lo = ((a & (Q_ONE - 1)) * b) >> FRAC_BITS;
      return sat_add(hi, lo, RANK_TOP);
   endfunction

   function automatic longint unsigned edge_clip(longint unsigned off);
      return (off > MAX_EDGES) ? MAX_EDGES : off;
   endfunction

   // Apply one accepted command to the shadow graph; queue its response, if any.
   function automatic void apply_pagerank_cmd(pr_cmd_t c);
      pr_rsp_t         r;
      longint unsigned n, base, nv, d, lo, hi, share, nb, change;
      int              it;
      bit              conv, has_rsp;
      r = '0;
      r.kind = KIND_INDEX_ERR;
      has_rsp = 1'b1;
      n = c_vcount;
      if (n == 0) n = 1;
      if (n > MAX_VERTICES) n = MAX_VERTICES;
      case (c.command)
         CMD_LOAD_OFFSET: begin
            if (c.index <= MAX_VERTICES) begin
               g_offset[c.index] = c.value;
               has_rsp = 1'b0;
            end
         end
         CMD_LOAD_NEIGHBOR: begin
            if (c.index < MAX_EDGES) begin
               g_nbr[c.index] = c.value;
               has_rsp = 1'b0;
            end
         end
         CMD_READ_RANK: begin
            if (c.index < n) begin
               r.kind = KIND_RANK;
               r.vertex = c.index[9:0];
               r.rank = g_rank[c.index][31:0];
            end
         end
         default: begin
            for (int v = 0; v < MAX_VERTICES; v++) begin
               g_rank[v] = Q_ONE;
               g_sum[v] = 0;
               g_active[v] = 1'b1;
            end
            change = 0;
            base = (c_damp >= Q_ONE) ? 0 : (Q_ONE - c_damp) / n;
            conv = 1'b0;
            it = 0;
            while (it < c_maxit && !conv) begin
               // update pass over the active set
               for (int v = 0; v < n; v++) begin
                  if (g_active[v]) begin
                     nv = sat_add(q30_mul(g_sum[v], c_damp), base, RANK_TOP);
                     d = (nv > g_rank[v]) ? nv - g_rank[v] : g_rank[v] - nv;
                     g_rank[v] = nv;
                     change = sat_add(change, d, CHG_TOP);
                  end
               end
               if (change < c_eps) begin
                  conv = 1'b1;
               end else begin
                  change = 0;
                  for (int v = 0; v < MAX_VERTICES; v++) begin
                     g_sum[v] = 0;
                     g_next[v] = 1'b0;
                  end
                  // spread pass: share = rank / out_degree, bad ids still count
                  for (int v = 0; v < n; v++) begin
                     if (g_active[v]) begin
                        lo = edge_clip(g_offset[v]);
                        hi = edge_clip(g_offset[v+1]);
                        if (hi > lo) begin
                           share = g_rank[v] / (hi - lo);
                           for (longint unsigned e = lo; e < hi; e++) begin
                              nb = g_nbr[e];
                              if (nb < n) begin
                                 g_sum[nb] = sat_add(g_sum[nb], share, RANK_TOP);
                                 g_next[nb] = 1'b1;
                              end
                           end
                        end
                     end
                  end
                  for (int v = 0; v < MAX_VERTICES; v++) g_active[v] = g_next[v];
                  it++;
               end
            end
            r.kind = KIND_RUN_DONE;
            r.iters = it[9:0];
            r.conv = conv;
         end
      endcase
      if (has_rsp) expected_rsp.push_back(r);
   endfunction

   // ------------------------------------------------------------------
   // Request driver: bursts of random length, random gaps
   // ------------------------------------------------------------------
   pr_cmd_t drv_cmd;
   int      burst_left = 4;
   int      gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) apply_pagerank_cmd(drv_cmd);
         if (req_valid && req_stall) begin
            // stalled: payload holds
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            drv_cmd = pending_cmds.pop_front();
            req_command <= drv_cmd.command;
            req_index <= drv_cmd.index;
            req_value <= drv_cmd.value;
            req_valid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Response stall pattern, plus one long hold-off once armed
   // ------------------------------------------------------------------
   bit hold_armed = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int stall_mode = 0;
   int mode_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_armed && !hold_done && rsp_valid) begin
         // long hold: input side backs up behind the pending response
         hold_done = 1'b1;
         hold_left = 400;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(16, 128);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= $urandom_range(0, 1);
            default: rsp_stall <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Response monitor
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      pr_rsp_t got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_result_kind, rsp_vertex, rsp_rank, rsp_iterations_run, rsp_converged};
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response kind=%0d vertex=%0d rank=%h iters=%0d conv=%0d",
                     $time, got.kind, got.vertex, got.rank, got.iters, got.conv);
            fail_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected kind=%0d vertex=%0d rank=%h iters=%0d conv=%0d",
                        $time, want.kind, want.vertex, want.rank, want.iters, want.conv);
               $display("%0t:          actual   kind=%0d vertex=%0d rank=%h iters=%0d conv=%0d",
                        $time, got.kind, got.vertex, got.rank, got.iters, got.conv);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: cycles without any transfer on either channel
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic queue_cmd(logic [1:0] cmd, int idx, int val);
      pending_cmds.push_back('{cmd, idx[13:0], val[13:0]});
      cmds_queued++;
   endtask

   // sender pause: all queued, all answered, then loads allowed to settle
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || req_valid || expected_rsp.size() != 0);
      repeat (10) @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [30:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_VERTEX_COUNT: c_vcount = data[10:0];
         CSR_MAX_ITER:     c_maxit = data[9:0];
         CSR_DAMPING:      c_damp = data;
         default:          c_eps = data;
      endcase
   endtask

   task automatic set_config(int vcount, int maxit, logic [30:0] damp, logic [30:0] eps);
      wait_drained();
      csr_write(CSR_VERTEX_COUNT, vcount);
      csr_write(CSR_MAX_ITER, maxit);
      csr_write(CSR_DAMPING, damp);
      csr_write(CSR_EPSILON, eps);
   endtask

   // Offsets for slots 0..n, then every edge slot they cover. near_top puts
   // the graph at the end of edge memory with some offsets past it.
   task automatic load_graph(int n, bit sparse, bit near_top);
      int offs [0:MAX_VERTICES];
      int off, lo, hi;
      off = near_top ? 8185 : $urandom_range(0, 7000);
      for (int s = 0; s <= n; s++) begin
         offs[s] = off;
         queue_cmd(CMD_LOAD_OFFSET, s, off);
         case ($urandom_range(0, 15))
            0: off = off - $urandom_range(0, (off < 3) ? off : 3);
            1: off = near_top ? $urandom_range(8193, 16383) : off;
            default: off = off + ((sparse && $urandom_range(0, 7) != 0) ? 0 : $urandom_range(0, 3));
         endcase
         if (off > 16383) off = 16383;
      end
      for (int v = 0; v < n; v++) begin
         lo = edge_clip(offs[v]);
         hi = edge_clip(offs[v+1]);
         for (int e = lo; e < hi; e++)
            queue_cmd(CMD_LOAD_NEIGHBOR, e,
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16383)
                                                  : $urandom_range(0, n - 1));
      end
   endtask

   // bad indexes, random reads and neighbor rewrites
   task automatic queue_noise(int n);
      case ($urandom_range(0, 5))
         0: queue_cmd(CMD_LOAD_OFFSET, $urandom_range(1025, 16383), $urandom_range(0, 16383));
         1: queue_cmd(CMD_LOAD_NEIGHBOR, $urandom_range(8192, 16383), $urandom_range(0, 16383));
         2: queue_cmd(CMD_READ_RANK, $urandom_range(0, 16383), $urandom_range(0, 16383));
         3: queue_cmd(CMD_LOAD_NEIGHBOR, $urandom_range(0, 8191), $urandom_range(0, 16383));
         default: queue_cmd(CMD_READ_RANK, $urandom_range(0, n - 1), $urandom_range(0, 16383));
      endcase
   endtask

   function automatic logic [30:0] pick_damping();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 31'(Q_ONE);
         2: return $urandom_range(800_000_000, 1_000_000_000);
         default: return 31'd0;
      endcase
   endfunction

   function automatic logic [30:0] pick_epsilon();
      case ($urandom_range(0, 3))
         0: return 31'd0;
         1: return $urandom_range(0, 1000);
         2: return $urandom;
         default: return $urandom_range(0, 1 << 24);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      int vc, n, cnt;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed, default CSRs (N=1): bad slots, reads out of range,
      // top valid slots, self loop plus a bad neighbor id
      queue_cmd(CMD_READ_RANK, 5, 0);
      queue_cmd(CMD_READ_RANK, 16383, 16383);
      queue_cmd(CMD_LOAD_OFFSET, 1025, 0);
      queue_cmd(CMD_LOAD_OFFSET, 16383, 16383);
      queue_cmd(CMD_LOAD_NEIGHBOR, 8192, 0);
      queue_cmd(CMD_LOAD_NEIGHBOR, 16383, 16383);
      queue_cmd(CMD_LOAD_OFFSET, 1024, 0);
      queue_cmd(CMD_LOAD_OFFSET, 0, 0);
      queue_cmd(CMD_LOAD_OFFSET, 1, 2);
      queue_cmd(CMD_LOAD_NEIGHBOR, 0, 0);
      queue_cmd(CMD_LOAD_NEIGHBOR, 1, 16383);
      queue_cmd(CMD_LOAD_NEIGHBOR, 8191, 16383);
      queue_cmd(CMD_RUN, 0, 0);
      queue_cmd(CMD_READ_RANK, 0, 0);
      queue_cmd(CMD_READ_RANK, 1, 0);

      // vertex count 0 acts as 1, zero iteration limit, damping saturated
      set_config(0, 0, 31'h7FFF_FFFF, 0);
      queue_cmd(CMD_RUN, 0, 0);
      queue_cmd(CMD_READ_RANK, 0, 0);
      queue_cmd(CMD_READ_RANK, 1, 0);

      // saturating products, epsilon at top so the first check converges
      set_config(1, 3, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      queue_cmd(CMD_RUN, 0, 0);
      queue_cmd(CMD_READ_RANK, 0, 0);

      // full size graph, damping exactly 1.0 (base term zero)
      set_config(MAX_VERTICES, 2, 31'(Q_ONE), 0);
      load_graph(MAX_VERTICES, 1'b1, 1'b0);
      queue_cmd(CMD_RUN, 0, 0);
      repeat (20) queue_cmd(CMD_READ_RANK, $urandom_range(0, MAX_VERTICES - 1), 0);
      queue_cmd(CMD_READ_RANK, MAX_VERTICES - 1, 0);

      // count above the maximum clamps to 1024
      set_config(2047, 1, 31'd912680550, 31'd11);
      queue_cmd(CMD_RUN, 0, 0);
      queue_cmd(CMD_READ_RANK, 1023, 0);
      queue_cmd(CMD_READ_RANK, 1024, 0);

      // iteration limit at top, no damping: change hits zero but never below 0
      set_config(2, 1023, 0, 0);
      load_graph(2, 1'b0, 1'b0);
      queue_cmd(CMD_RUN, 0, 0);
      queue_cmd(CMD_READ_RANK, 0, 0);
      queue_cmd(CMD_READ_RANK, 1, 0);

      // offsets past the end of edge memory
      set_config(3, 5, pick_damping(), pick_epsilon());
      load_graph(3, 1'b0, 1'b1);
      queue_cmd(CMD_RUN, 0, 0);
      queue_cmd(CMD_READ_RANK, 2, 0);

      // Random phases: fresh small graph and CSRs, runs mixed with noise
      hold_armed = 1'b1;
      while (cmds_queued < ITEM_GOAL) begin
         vc = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 16);
         n = (vc == 0) ? 1 : vc;
         set_config(vc, ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8),
                    pick_damping(), pick_epsilon());
         load_graph(n, 1'b0, 1'b0);
         queue_cmd(CMD_RUN, 0, 0);
         cnt = $urandom_range(20, 50);
         for (int i = 0; i < cnt; i++) begin
            if ($urandom_range(0, 11) == 0) queue_cmd(CMD_RUN, 0, 0);
            else queue_noise(n);
         end
      end

      wait_drained();
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
